/* rtl/utf8d_pkg.sv */
// Shared types and constants for the UTF-8 byte decoder.
`timescale 1ns / 1ps

package utf8d_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CodeW = 21;
  localparam int unsigned StatW = 3;

  localparam logic [CodeW-1:0] ReplResetVal = 21'h00FFFD;

  typedef enum logic [StatW-1:0] {
    ST_IDLE   = 3'd0,
    ST_ACCEPT = 3'd1,
    ST_REJECT = 3'd2,
    ST_EXP1   = 3'd3,
    ST_EXP2   = 3'd4,
    ST_EXP3   = 3'd5
  } parse_state_t;

  typedef struct packed {
    parse_state_t     state;
    logic [CodeW-1:0] accum;
  } dec_state_t;

  typedef struct packed {
    parse_state_t     status;
    logic [CodeW-1:0] char_out;
  } dec_res_t;

endpackage

/* rtl/utf8_byte_decoder_core.sv */
// Top level of the byte-serial UTF-8 decoder.
//
//   port group  dir  handshake            payload
//   in_*        in   in_valid/in_ready    in_byte_in[7:0], in_restart
//   out_*       out  out_valid/out_ready  out_status[2:0], out_char_out[20:0]
//   cfg_*       in   cfg_valid/cfg_ready  cfg_data[20:0] (replacement char)
//
// One request per cycle unless out_ready stalls the result register.
// The parse state advances when a request moves from the input register to
// the result register, through one level of byte decode logic.
// Synchronous active-low reset: idle state, accumulator zero, replacement U+FFFD.
// A stalled result holds; the input register still takes one more request.
`timescale 1ns / 1ps

module utf8_byte_decoder_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [utf8d_pkg::ByteW-1:0] in_byte_in,
  input  logic                       in_restart,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [utf8d_pkg::StatW-1:0] out_status,
  output logic [utf8d_pkg::CodeW-1:0] out_char_out,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [utf8d_pkg::CodeW-1:0] cfg_data
);
  import utf8d_pkg::*;

  logic             stg_vld;
  logic [ByteW-1:0] stg_byte;
  logic             stg_restart;
  logic             out_free;
  logic             advance;
  logic [CodeW-1:0] repl_r;
  dec_state_t       dec_r;
  dec_state_t       dec_nxt;
  dec_res_t         dec_res;

  assign cfg_ready = 1'b1;
  assign advance   = stg_vld && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repl_r <= ReplResetVal;
    end else if (cfg_valid && cfg_ready) begin
      repl_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_r.state <= ST_IDLE;
      dec_r.accum <= '0;
    end else if (advance) begin
      dec_r <= dec_nxt;
    end
  end

  utf8d_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte_in (in_byte_in),
    .in_restart (in_restart),
    .take       (advance),
    .vld        (stg_vld),
    .byte_q     (stg_byte),
    .restart_q  (stg_restart)
  );

  utf8d_step u_step (
    .byte_q    (stg_byte),
    .restart_q (stg_restart),
    .cur       (dec_r),
    .repl_char (repl_r),
    .nxt       (dec_nxt),
    .res       (dec_res)
  );

  utf8d_out_stage u_out (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (advance),
    .res          (dec_res),
    .free         (out_free),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_char_out (out_char_out)
  );

endmodule

/* rtl/utf8d_in_stage.sv */
// Input register stage holding one accepted request.
`timescale 1ns / 1ps

module utf8d_in_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [utf8d_pkg::ByteW-1:0] in_byte_in,
  input  logic                       in_restart,
  input  logic                       take,
  output logic                       vld,
  output logic [utf8d_pkg::ByteW-1:0] byte_q,
  output logic                       restart_q
);
  import utf8d_pkg::*;

  logic             vld_r;
  logic             vld_nxt;
  logic [ByteW-1:0] byte_r;
  logic             restart_r;

  assign in_ready = !vld_r || take;
  assign vld_nxt  = in_ready ? in_valid : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r    <= in_byte_in;
      restart_r <= in_restart;
    end
  end

  assign vld       = vld_r;
  assign byte_q    = byte_r;
  assign restart_q = restart_r;

endmodule

/* rtl/utf8d_step.sv */
// Next-state and character logic for one byte or restart request.
`timescale 1ns / 1ps

module utf8d_step (
  input  logic [utf8d_pkg::ByteW-1:0] byte_q,
  input  logic                       restart_q,
  input  utf8d_pkg::dec_state_t      cur,
  input  logic [utf8d_pkg::CodeW-1:0] repl_char,
  output utf8d_pkg::dec_state_t      nxt,
  output utf8d_pkg::dec_res_t        res
);
  import utf8d_pkg::*;

  logic is_cont;

  assign is_cont = (byte_q[7:6] == 2'b10);

  always_comb begin
    nxt = cur;
    if (restart_q) begin
      nxt.state = ST_IDLE;
    end else begin
      case (cur.state)
        ST_IDLE, ST_ACCEPT, ST_REJECT: begin
          if (byte_q[7:1] == 7'b1100000) begin
            nxt.state = ST_REJECT;
          end else if (!byte_q[7]) begin
            nxt.accum = {13'd0, byte_q};
            nxt.state = ST_ACCEPT;
          end else if (is_cont) begin
            nxt.state = ST_IDLE;
          end else if (byte_q[7:5] == 3'b110) begin
            nxt.accum = {10'd0, byte_q[4:0], 6'd0};
            nxt.state = ST_EXP1;
          end else if (byte_q[7:4] == 4'b1110) begin
            nxt.accum = {5'd0, byte_q[3:0], 12'd0};
            nxt.state = ST_EXP2;
          end else if (byte_q[7:3] == 5'b11110) begin
            nxt.accum = {byte_q[2:0], 18'd0};
            nxt.state = ST_EXP3;
          end else begin
            nxt.state = ST_REJECT;
          end
        end
        ST_EXP3: begin
          nxt.accum = cur.accum | {3'd0, byte_q[5:0], 12'd0};
          nxt.state = is_cont ? ST_EXP2 : ST_REJECT;
        end
        ST_EXP2: begin
          nxt.accum = cur.accum | {9'd0, byte_q[5:0], 6'd0};
          nxt.state = is_cont ? ST_EXP1 : ST_REJECT;
        end
        ST_EXP1: begin
          nxt.accum = cur.accum | {15'd0, byte_q[5:0]};
          nxt.state = is_cont ? ST_ACCEPT : ST_REJECT;
        end
        default: begin
          nxt.state = ST_REJECT;
        end
      endcase
    end
  end

  assign res.status   = nxt.state;
  assign res.char_out = (nxt.state == ST_ACCEPT) ? nxt.accum : repl_char;

endmodule

/* rtl/utf8d_out_stage.sv */
// Result register stage for decoded status and character.
`timescale 1ns / 1ps

module utf8d_out_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  utf8d_pkg::dec_res_t        res,
  output logic                       free,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [utf8d_pkg::StatW-1:0] out_status,
  output logic [utf8d_pkg::CodeW-1:0] out_char_out
);
  import utf8d_pkg::*;

  logic     vld_r;
  logic     vld_nxt;
  dec_res_t res_r;

  assign free    = !vld_r || out_ready;
  assign vld_nxt = load || (vld_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid    = vld_r;
  assign out_status   = res_r.status;
  assign out_char_out = res_r.char_out;

endmodule
